### design/tun_pkg.sv
// Package: payload types and constants for the triangle unit normal block
package tun_pkg;

    localparam int VertexDepthDefault = 1024;
    localparam int IndexW             = 10;
    localparam int CoordW             = 16;
    localparam int NormW              = 16;
    localparam int CrossW             = 35;
    localparam int MagW               = 30;
    localparam int SumW               = 62;
    localparam int RootW              = 31;
    localparam int QuotW              = 15;

    localparam logic MODE_WRITE   = 1'b0;
    localparam logic MODE_REQUEST = 1'b1;

    typedef struct packed {
        logic               mode;
        logic [IndexW-1:0]  vertex_index;
        logic signed [CoordW-1:0] coord_x;
        logic signed [CoordW-1:0] coord_y;
        logic signed [CoordW-1:0] coord_z;
        logic [IndexW-1:0]  corner_a;
        logic [IndexW-1:0]  corner_b;
        logic [IndexW-1:0]  corner_c;
    } tun_in_t;

    typedef struct packed {
        logic signed [NormW-1:0] normal_x;
        logic signed [NormW-1:0] normal_y;
        logic signed [NormW-1:0] normal_z;
        logic                    degenerate;
    } tun_out_t;

endpackage

### design/triangle_unit_normal.sv
// Top level: vertex store and sequential unit-normal engine
// A write beat is taken while busy is low and leaves busy low. A normal request
// holds busy while it runs; a zero cross product ends the request early, without
// the squares, root and divisions. The work goes to three store reads, six 17x17
// products formed one multiplier bit per cycle, a scaling shift of one place per
// cycle, three squares formed one bit per cycle, a 31-step bit-serial square root
// and three 45-step restoring divisions sharing one divider. The result is shown
// for one cycle with done high and cannot be stalled; the next start is taken in
// the same cycle.
module triangle_unit_normal #(
    parameter int VERTEX_DEPTH = tun_pkg::VertexDepthDefault
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  tun_pkg::tun_in_t cmd,
    output logic             done,
    output tun_pkg::tun_out_t result
);
    import tun_pkg::*;

    localparam int AddrW = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;

    typedef enum logic [3:0] {
        S_IDLE, S_RDA, S_RDB, S_RDC, S_DIFF, S_MUL, S_CROSS, S_SHIFT,
        S_SQ, S_SQRT, S_DIV, S_OUT
    } state_t;

    state_t state_reg;

    logic [3*CoordW-1:0] mem [VERTEX_DEPTH];
    logic [3*CoordW-1:0] rd_reg;
    logic [AddrW-1:0]    rd_addr;
    logic                rd_ok_reg;

    logic [IndexW-1:0] ib_reg, ic_reg;
    logic signed [CoordW:0] ax_reg, ay_reg, az_reg, bx_reg, by_reg, bz_reg;
    logic signed [CoordW:0] u_reg [3];
    logic signed [CoordW:0] v_reg [3];

    // six products: u1v2 u2v1 u2v0 u0v2 u0v1 u1v0, shift-add over 17 bits
    logic signed [2*CoordW+2:0] p_reg [6];
    logic [CoordW:0]            mb_reg [6];
    logic signed [CoordW:0]     mc_reg [6];
    logic [5:0]  cnt_reg;
    logic [2:0]  neg_reg;
    logic [CrossW:0] mag_reg [3];
    logic [SumW-1:0] sum_reg;
    logic [1:0]  sq_idx_reg;
    logic [RootW-1:0] root_reg;
    logic [SumW+1:0]  rem_reg;
    logic [SumW-1:0]  rad_reg;
    logic [1:0]  dv_idx_reg;
    logic [MagW+14:0] num_reg;
    logic [RootW:0]   drem_reg;
    logic [QuotW+16:0] quo_reg;
    logic [NormW-1:0] n_reg [3];

    logic [CrossW:0] mx;
    assign mx = mag_reg[0] | mag_reg[1] | mag_reg[2];
    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        case (state_reg)
            S_IDLE:  rd_addr = AddrW'(cmd.corner_a);
            S_RDA:   rd_addr = AddrW'(ib_reg);
            default: rd_addr = AddrW'(ic_reg);
        endcase
    end

    logic ok_next;
    always_comb
    begin
        case (state_reg)
            S_IDLE:  ok_next = (32'(cmd.corner_a) < VERTEX_DEPTH);
            S_RDA:   ok_next = (32'(ib_reg) < VERTEX_DEPTH);
            default: ok_next = (32'(ic_reg) < VERTEX_DEPTH);
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy && cmd.mode == MODE_WRITE &&
            32'(cmd.vertex_index) < VERTEX_DEPTH)
        begin
            mem[AddrW'(cmd.vertex_index)] <= {cmd.coord_z, cmd.coord_y, cmd.coord_x};
        end
        rd_reg <= mem[rd_addr];
    end

    logic [3*CoordW-1:0] vtx;
    assign vtx = rd_ok_reg ? rd_reg : '0;

    // sqrt step helpers
    logic [SumW+1:0] rem_sh;
    assign rem_sh = {rem_reg[SumW-1:0], rad_reg[SumW-1:SumW-2]};
    logic [SumW+1:0] tcmp;
    assign tcmp = {{(SumW-RootW){1'b0}}, root_reg, 2'b01};
    logic [SumW+1:0] trial;
    assign trial = rem_sh - tcmp;

    logic [RootW:0] dsh;
    assign dsh = {drem_reg[RootW-1:0], num_reg[MagW+14]};
    logic qbit;
    assign qbit = (dsh >= {1'b0, root_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done      <= 1'b0;
            rd_ok_reg <= 1'b0;
        end
        else
        begin
            done      <= 1'b0;
            rd_ok_reg <= ok_next;
            case (state_reg)
                S_IDLE:
                begin
                    if (start && cmd.mode == MODE_REQUEST)
                    begin
                        ib_reg    <= cmd.corner_b;
                        ic_reg    <= cmd.corner_c;
                        state_reg <= S_RDA;
                    end
                end
                S_RDA:
                begin
                    ax_reg <= 17'(signed'(vtx[15:0]));
                    ay_reg <= 17'(signed'(vtx[31:16]));
                    az_reg <= 17'(signed'(vtx[47:32]));
                    state_reg <= S_RDB;
                end
                S_RDB:
                begin
                    bx_reg <= 17'(signed'(vtx[15:0]));
                    by_reg <= 17'(signed'(vtx[31:16]));
                    bz_reg <= 17'(signed'(vtx[47:32]));
                    state_reg <= S_RDC;
                end
                S_RDC:
                begin
                    state_reg <= S_DIFF;
                end
                S_DIFF:
                begin
                    u_reg[0] <= 17'(signed'(vtx[15:0])) - ax_reg;
                    u_reg[1] <= 17'(signed'(vtx[31:16])) - ay_reg;
                    u_reg[2] <= 17'(signed'(vtx[47:32])) - az_reg;
                    v_reg[0] <= bx_reg - ax_reg;
                    v_reg[1] <= by_reg - ay_reg;
                    v_reg[2] <= bz_reg - az_reg;
                    state_reg <= S_CROSS;
                    cnt_reg   <= '0;
                end
                S_CROSS:
                begin
                    mc_reg[0] <= u_reg[1]; mb_reg[0] <= v_reg[2];
                    mc_reg[1] <= u_reg[2]; mb_reg[1] <= v_reg[1];
                    mc_reg[2] <= u_reg[2]; mb_reg[2] <= v_reg[0];
                    mc_reg[3] <= u_reg[0]; mb_reg[3] <= v_reg[2];
                    mc_reg[4] <= u_reg[0]; mb_reg[4] <= v_reg[1];
                    mc_reg[5] <= u_reg[1]; mb_reg[5] <= v_reg[0];
                    for (int i = 0; i < 6; i++) p_reg[i] <= '0;
                    cnt_reg   <= '0;
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    // MSB-first shift-add; top bit of the multiplier has negative weight
                    for (int i = 0; i < 6; i++)
                    begin
                        if (mb_reg[i][CoordW])
                        begin
                            if (cnt_reg == 6'd0)
                                p_reg[i] <= (p_reg[i] <<< 1) - 35'(mc_reg[i]);
                            else
                                p_reg[i] <= (p_reg[i] <<< 1) + 35'(mc_reg[i]);
                        end
                        else
                            p_reg[i] <= p_reg[i] <<< 1;
                        mb_reg[i] <= mb_reg[i] << 1;
                    end
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'(CoordW))
                        state_reg <= S_SHIFT;
                end
                S_SHIFT:
                begin
                    if (cnt_reg != 6'd0)
                    begin
                        // first entry: form cross and magnitudes
                        logic signed [CrossW:0] c0, c1, c2;
                        c0 = 36'(p_reg[0]) - 36'(p_reg[1]);
                        c1 = 36'(p_reg[2]) - 36'(p_reg[3]);
                        c2 = 36'(p_reg[4]) - 36'(p_reg[5]);
                        neg_reg <= {c2[CrossW], c1[CrossW], c0[CrossW]};
                        mag_reg[0] <= c0[CrossW] ? 36'(-c0) : 36'(c0);
                        mag_reg[1] <= c1[CrossW] ? 36'(-c1) : 36'(c1);
                        mag_reg[2] <= c2[CrossW] ? 36'(-c2) : 36'(c2);
                        cnt_reg <= '0;
                    end
                    else if (mx == '0)
                    begin
                        for (int i = 0; i < 3; i++) n_reg[i] <= '0;
                        result.degenerate <= 1'b1;
                        state_reg <= S_OUT;
                    end
                    else if (mx[CrossW:MagW] != '0)
                    begin
                        for (int i = 0; i < 3; i++) mag_reg[i] <= mag_reg[i] >> 1;
                    end
                    else if (!mx[MagW-1])
                    begin
                        for (int i = 0; i < 3; i++) mag_reg[i] <= mag_reg[i] << 1;
                    end
                    else
                    begin
                        sum_reg    <= '0;
                        sq_idx_reg <= '0;
                        cnt_reg    <= '0;
                        mc_reg[0]  <= '0;
                        state_reg  <= S_SQ;
                    end
                end
                S_SQ:
                begin
                    // squares by shift-add, one multiplier bit per cycle
                    if (mag_reg[sq_idx_reg][MagW-1-cnt_reg])
                        rad_reg <= ((cnt_reg == 6'd0) ? 62'd0 : (rad_reg << 1))
                                   + 62'(mag_reg[sq_idx_reg][MagW-1:0]);
                    else
                        rad_reg <= (cnt_reg == 6'd0) ? 62'd0 : (rad_reg << 1);
                    if (cnt_reg == 6'(MagW-1))
                    begin
                        cnt_reg <= '0;
                        if (sq_idx_reg == 2'd2)
                        begin
                            state_reg <= S_SQRT;
                            root_reg  <= '0;
                            rem_reg   <= '0;
                        end
                        sq_idx_reg <= sq_idx_reg + 2'd1;
                    end
                    else
                        cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd0 && sq_idx_reg != 2'd0)
                        sum_reg <= sum_reg + rad_reg;
                    if (cnt_reg == 6'd0 && sq_idx_reg == 2'd0)
                        sum_reg <= '0;
                end
                S_SQRT:
                begin
                    if (cnt_reg == 6'd0 && root_reg == '0 && rem_reg == '0 &&
                        sq_idx_reg == 2'd3)
                    begin
                        rad_reg    <= sum_reg + rad_reg;
                        sq_idx_reg <= '0;
                    end
                    else
                    begin
                        if (rem_sh >= tcmp)
                        begin
                            rem_reg  <= trial;
                            root_reg <= {root_reg[RootW-2:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg  <= rem_sh;
                            root_reg <= {root_reg[RootW-2:0], 1'b0};
                        end
                        rad_reg <= rad_reg << 2;
                        if (cnt_reg == 6'(RootW-1))
                        begin
                            // root_reg still lacks its last bit, so it is half the root
                            dv_idx_reg <= '0;
                            cnt_reg    <= '0;
                            num_reg    <= {1'b0, mag_reg[0][MagW-1:0], 14'd0}
                                          + 45'(root_reg[RootW-2:0]);
                            drem_reg   <= '0;
                            state_reg  <= S_DIV;
                        end
                        else
                            cnt_reg <= cnt_reg + 6'd1;
                    end
                end
                S_DIV:
                begin
                    if (cnt_reg == 6'(MagW+14))
                    begin
                        cnt_reg  <= '0;
                        drem_reg <= '0;
                        n_reg[dv_idx_reg] <= neg_reg[dv_idx_reg]
                            ? 16'(-{quo_reg[14:0], qbit})
                            : {quo_reg[14:0], qbit};
                        dv_idx_reg <= dv_idx_reg + 2'd1;
                        if (dv_idx_reg == 2'd2)
                        begin
                            result.degenerate <= 1'b0;
                            state_reg <= S_OUT;
                        end
                        else
                            num_reg <= {1'b0, mag_reg[dv_idx_reg+2'd1][MagW-1:0], 14'd0}
                                       + 45'(root_reg[RootW-1:1]);
                    end
                    else
                    begin
                        drem_reg <= qbit ? dsh - {1'b0, root_reg} : dsh;
                        quo_reg  <= (cnt_reg == 6'd0) ? {31'd0, qbit}
                                                      : {quo_reg[QuotW+15:0], qbit};
                        num_reg  <= num_reg << 1;
                        cnt_reg  <= cnt_reg + 6'd1;
                    end
                end
                S_OUT:
                begin
                    result.normal_x <= n_reg[0];
                    result.normal_y <= n_reg[1];
                    result.normal_z <= n_reg[2];
                    done      <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
